// File: hw/rtl/lbc_pkg.sv
// ============================================================================
// lbc_pkg - shared types and constants of the line rectangle clipper
// Channel payloads, per-lane division side data and register indexes.
// ============================================================================
package lbc_pkg;

    localparam int COORD_W   = 24;   // Q16.8 coordinate
    localparam int DIFF_W    = 25;   // endpoint difference
    localparam int MAG_W     = 24;   // |p| and divider remainder
    localparam int RECT_W    = 16;   // rectangle registers
    localparam int CFG_IDX_W = 2;
    localparam int NUM_LANES = 4;    // left, right, top, bottom

    localparam logic [CFG_IDX_W-1:0] CFG_RECT_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic                      extend_start;
        logic                      extend_end;
    } seg_t;

    typedef struct packed {
        logic                      visible;
        logic signed [COORD_W-1:0] clip_start_x;
        logic signed [COORD_W-1:0] clip_start_y;
        logic signed [COORD_W-1:0] clip_end_x;
        logic signed [COORD_W-1:0] clip_end_y;
    } clip_t;

    // segment data that rides along the pipeline
    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic                      ext_start;
        logic                      ext_end;
    } lbc_item_t;

    // one boundary term: |p| and the signs needed to rebuild t
    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             pzero;
        logic             pneg;
        logic             qneg;
        logic             ovf;
    } lbc_lane_t;

    typedef struct packed {
        lbc_item_t                       item;
        lbc_lane_t [NUM_LANES-1:0]       lane;
    } lbc_side_t;

endpackage

// File: hw/rtl/lbc_div_cell.sv
// ============================================================================
// lbc_div_cell - one quotient bit of the four boundary divisions
// Restoring step on each lane; side data passes to the next cell.
// ============================================================================
module lbc_div_cell
    import lbc_pkg::*;
#(
    parameter int QUO_W = 48
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  logic                                valid_in,
    input  lbc_side_t                           side_in,
    input  logic [NUM_LANES-1:0][MAG_W-1:0]     rem_in,
    input  logic [NUM_LANES-1:0][QUO_W-1:0]     quo_in,
    output logic                                valid_out,
    output lbc_side_t                           side_out,
    output logic [NUM_LANES-1:0][MAG_W-1:0]     rem_out,
    output logic [NUM_LANES-1:0][QUO_W-1:0]     quo_out
);

    logic                            valid_reg;
    lbc_side_t                       side_reg;
    logic [NUM_LANES-1:0][MAG_W-1:0] rem_reg, rem_next;
    logic [NUM_LANES-1:0][QUO_W-1:0] quo_reg, quo_next;
    logic [MAG_W:0]                  shifted [NUM_LANES];
    logic [MAG_W+1:0]                trial   [NUM_LANES];

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            shifted[i] = {rem_in[i], quo_in[i][QUO_W-1]};
            trial[i]   = {1'b0, shifted[i]} - {2'b00, side_in.lane[i].mag};
            if (!trial[i][MAG_W+1])
                rem_next[i] = trial[i][MAG_W-1:0];
            else
                rem_next[i] = shifted[i][MAG_W-1:0];
            quo_next[i] = {quo_in[i][QUO_W-2:0], ~trial[i][MAG_W+1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg <= side_in;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;

endmodule

// File: hw/rtl/lbc_bound_cell.sv
// ============================================================================
// lbc_bound_cell - one Liang-Barsky boundary update
// Applies lane 0 to tmin/tmax, then rotates the lanes for the next cell.
// ============================================================================
module lbc_bound_cell
    import lbc_pkg::*;
#(
    parameter int T_W = 48
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              valid_in,
    input  lbc_side_t                         side_in,
    input  logic [NUM_LANES-1:0][T_W-1:0]     t_in,
    input  logic                              vis_in,
    input  logic signed [T_W-1:0]             tmin_in,
    input  logic signed [T_W-1:0]             tmax_in,
    output logic                              valid_out,
    output lbc_side_t                         side_out,
    output logic [NUM_LANES-1:0][T_W-1:0]     t_out,
    output logic                              vis_out,
    output logic signed [T_W-1:0]             tmin_out,
    output logic signed [T_W-1:0]             tmax_out
);

    logic                          valid_reg;
    lbc_side_t                     side_reg, side_next;
    logic [NUM_LANES-1:0][T_W-1:0] t_reg, t_next;
    logic                          vis_reg, vis_next;
    logic signed [T_W-1:0]         tmin_reg, tmin_next;
    logic signed [T_W-1:0]         tmax_reg, tmax_next;
    logic signed [T_W-1:0]         t_cur;
    lbc_lane_t                     ln;
    logic                          gt_max, gt_min, lt_min, lt_max;

    assign t_cur  = $signed(t_in[0]);
    assign ln     = side_in.lane[0];
    assign gt_max = t_cur > tmax_in;
    assign gt_min = t_cur > tmin_in;
    assign lt_min = t_cur < tmin_in;
    assign lt_max = t_cur < tmax_in;

    always_comb
    begin
        vis_next  = vis_in;
        tmin_next = tmin_in;
        tmax_next = tmax_in;
        if (vis_in)
        begin
            if (ln.pzero)
            begin
                if (ln.qneg)
                    vis_next = 1'b0;
            end
            else if (ln.pneg)
            begin
                // entering edge
                if (gt_max && !side_in.item.ext_end)
                    vis_next = 1'b0;
                else
                begin
                    if (gt_max)
                        tmax_next = t_cur;
                    if (gt_min)
                        tmin_next = t_cur;
                end
            end
            else
            begin
                // leaving edge
                if (lt_min && !side_in.item.ext_start)
                    vis_next = 1'b0;
                else
                begin
                    if (lt_min)
                        tmin_next = t_cur;
                    if (lt_max)
                        tmax_next = t_cur;
                end
            end
        end
        side_next      = side_in;
        side_next.lane = {side_in.lane[0], side_in.lane[NUM_LANES-1:1]};
        t_next         = {t_in[0], t_in[NUM_LANES-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg <= side_next;
            t_reg    <= t_next;
            vis_reg  <= vis_next;
            tmin_reg <= tmin_next;
            tmax_reg <= tmax_next;
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign t_out     = t_reg;
    assign vis_out   = vis_reg;
    assign tmin_out  = tmin_reg;
    assign tmax_out  = tmax_reg;

endmodule

// File: hw/rtl/lbc_along.sv
// ============================================================================
// lbc_along - point on the line: base + t * dir, rounded half up, saturated
// Two register stages: split partial products, then their sum.
// ============================================================================
module lbc_along
    import lbc_pkg::*;
#(
    parameter int T_W       = 48,
    parameter int FRAC_BITS = 24
)
(
    input  logic                      clk,
    input  logic                      advance,
    input  logic signed [COORD_W-1:0] base,
    input  logic signed [DIFF_W-1:0]  dir,
    input  logic signed [T_W-1:0]     t,
    output logic signed [COORD_W-1:0] coord
);

    localparam int LO_W  = T_W / 2;
    localparam int HI_W  = T_W - LO_W;
    localparam int HP_W  = HI_W + DIFF_W;
    localparam int LP_W  = LO_W + 1 + DIFF_W;
    localparam int SUM_W = T_W + DIFF_W + 1;

    localparam logic signed [SUM_W-1:0] HALF  = SUM_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] C_MAX = (SUM_W'(1) <<< (COORD_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] C_MIN = -(SUM_W'(1) <<< (COORD_W - 1));

    logic signed [HP_W-1:0]    ph_reg, ph_next;
    logic signed [LP_W-1:0]    pl_reg, pl_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [COORD_W-1:0] base1_reg, base2_reg;
    logic signed [SUM_W-1:0]   off, wide;

    assign ph_next  = $signed(t[T_W-1:LO_W]) * dir;
    assign pl_next  = $signed({1'b0, t[LO_W-1:0]}) * dir;
    assign sum_next = (SUM_W'(ph_reg) <<< LO_W) + SUM_W'(pl_reg) + HALF;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ph_reg    <= ph_next;
            pl_reg    <= pl_next;
            base1_reg <= base;
            sum_reg   <= sum_next;
            base2_reg <= base1_reg;
        end
    end

    assign off  = sum_reg >>> FRAC_BITS;
    assign wide = off + SUM_W'(base2_reg);

    always_comb
    begin
        if (wide > C_MAX)
            coord = C_MAX[COORD_W-1:0];
        else if (wide < C_MIN)
            coord = C_MIN[COORD_W-1:0];
        else
            coord = wide[COORD_W-1:0];
    end

endmodule

// File: hw/rtl/line_rect_clipper_core.sv
// ============================================================================
// line_rect_clipper_core - Liang-Barsky segment clipper, axis-aligned rect
// The divider chain has 24 + PARAM_FRAC_BITS cells between seg and clip.
// Throughput: one transaction per cycle; all stages hold while clip is stalled.
// Reset: pipeline valids clear, rectangle registers clear to 0.
// ============================================================================
module line_rect_clipper_core
    import lbc_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 8,
    parameter int PARAM_FRAC_BITS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RECT_W-1:0]    cfg_data,
    input  logic                 seg_valid,
    output logic                 seg_stall,
    input  seg_t                 seg,
    output logic                 clip_valid,
    input  logic                 clip_stall,
    output clip_t                clip
);

    // t is signed with 24 integer bits; the divider makes one bit per cell
    localparam int T_W    = COORD_W + PARAM_FRAC_BITS;
    localparam int QUO_W  = T_W;
    // scaled rectangle edges: right/bottom need RECT_W + 2 bits before scaling
    localparam int EDGE_W = (RECT_W + 2 + COORD_FRAC_BITS > COORD_W) ?
                            (RECT_W + 2 + COORD_FRAC_BITS) : COORD_W;
    localparam int Q_W    = EDGE_W + 1;

    localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
    localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};
    localparam logic signed [T_W-1:0] T_ONE = T_W'(65'd1 << PARAM_FRAC_BITS);

    // ------------------------------------------------------------------
    // Rectangle registers
    // ------------------------------------------------------------------
    logic signed [RECT_W-1:0] rect_left_reg, rect_top_reg;
    logic        [RECT_W-1:0] rect_width_reg, rect_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg   <= '0;
            rect_top_reg    <= '0;
            rect_width_reg  <= '0;
            rect_height_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_RECT_LEFT:   rect_left_reg   <= $signed(cfg_data);
                CFG_RECT_TOP:    rect_top_reg    <= $signed(cfg_data);
                CFG_RECT_WIDTH:  rect_width_reg  <= cfg_data;
                CFG_RECT_HEIGHT: rect_height_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: every stage moves together unless the output
    // register holds a transaction that is stalled.
    // ------------------------------------------------------------------
    logic  advance;
    logic  clip_valid_reg;
    clip_t clip_reg, clip_next;

    assign advance   = !(clip_valid_reg && clip_stall);
    assign seg_stall = !advance;

    // ------------------------------------------------------------------
    // Boundary terms. Lanes: 0 left, 1 right, 2 top, 3 bottom.
    // p is the direction component, q the distance of start from the edge.
    // Each lane is set up for |q| * 2^F / |p|: the bits of |q| from bit 24
    // upward seed the remainder, the lower bits feed the cells.
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] x1, y1, x2, y2;
    logic signed [DIFF_W-1:0]  dx, dy;
    logic signed [RECT_W+1:0]  right_px, bottom_px;
    logic signed [EDGE_W-1:0]  left_sc, right_sc, top_sc, bottom_sc;
    logic signed [DIFF_W-1:0]  p     [NUM_LANES];
    logic signed [Q_W-1:0]     q     [NUM_LANES];
    logic [DIFF_W-1:0]         p_abs [NUM_LANES];
    logic [Q_W-1:0]            q_abs [NUM_LANES];

    lbc_side_t                       s0_side_next;
    logic [NUM_LANES-1:0][MAG_W-1:0] s0_rem_next;
    logic [NUM_LANES-1:0][QUO_W-1:0] s0_quo_next;

    assign x1 = seg.start_x;
    assign y1 = seg.start_y;
    assign x2 = seg.end_x;
    assign y2 = seg.end_y;
    assign dx = DIFF_W'(x2) - DIFF_W'(x1);
    assign dy = DIFF_W'(y2) - DIFF_W'(y1);

    assign right_px  = $signed({{2{rect_left_reg[RECT_W-1]}}, rect_left_reg})
                     + $signed({2'b00, rect_width_reg});
    assign bottom_px = $signed({{2{rect_top_reg[RECT_W-1]}}, rect_top_reg})
                     + $signed({2'b00, rect_height_reg});

    assign left_sc   = EDGE_W'(rect_left_reg) <<< COORD_FRAC_BITS;
    assign top_sc    = EDGE_W'(rect_top_reg) <<< COORD_FRAC_BITS;
    assign right_sc  = EDGE_W'(right_px) <<< COORD_FRAC_BITS;
    assign bottom_sc = EDGE_W'(bottom_px) <<< COORD_FRAC_BITS;

    always_comb
    begin
        p[0] = -dx;
        p[1] = dx;
        p[2] = -dy;
        p[3] = dy;
        q[0] = Q_W'(x1) - Q_W'(left_sc);
        q[1] = Q_W'(right_sc) - Q_W'(x1);
        q[2] = Q_W'(y1) - Q_W'(top_sc);
        q[3] = Q_W'(bottom_sc) - Q_W'(y1);

        s0_side_next.item.x1        = x1;
        s0_side_next.item.y1        = y1;
        s0_side_next.item.x2        = x2;
        s0_side_next.item.y2        = y2;
        s0_side_next.item.dx        = dx;
        s0_side_next.item.dy        = dy;
        s0_side_next.item.ext_start = seg.extend_start;
        s0_side_next.item.ext_end   = seg.extend_end;

        for (int i = 0; i < NUM_LANES; i++)
        begin
            p_abs[i] = p[i][DIFF_W-1] ? DIFF_W'(-p[i]) : DIFF_W'(p[i]);
            q_abs[i] = q[i][Q_W-1] ? Q_W'(-q[i]) : Q_W'(q[i]);
            s0_side_next.lane[i].mag   = p_abs[i][MAG_W-1:0];
            s0_side_next.lane[i].pzero = (p[i] == '0);
            s0_side_next.lane[i].pneg  = p[i][DIFF_W-1];
            s0_side_next.lane[i].qneg  = q[i][Q_W-1];
            // quotient of 2^(24+F) or more saturates regardless of sign
            s0_side_next.lane[i].ovf   =
                MAG_W'(q_abs[i][Q_W-1:MAG_W]) >= p_abs[i][MAG_W-1:0];
            s0_rem_next[i] = s0_side_next.lane[i].ovf ? '0 :
                             MAG_W'(q_abs[i][Q_W-1:MAG_W]);
            s0_quo_next[i] = {q_abs[i][MAG_W-1:0], {PARAM_FRAC_BITS{1'b0}}};
        end
    end

    // ------------------------------------------------------------------
    // Input stage and divider chain
    // ------------------------------------------------------------------
    logic                            div_valid [QUO_W+1];
    lbc_side_t                       div_side  [QUO_W+1];
    logic [NUM_LANES-1:0][MAG_W-1:0] div_rem   [QUO_W+1];
    logic [NUM_LANES-1:0][QUO_W-1:0] div_quo   [QUO_W+1];

    logic                            s0_valid_reg;
    lbc_side_t                       s0_side_reg;
    logic [NUM_LANES-1:0][MAG_W-1:0] s0_rem_reg;
    logic [NUM_LANES-1:0][QUO_W-1:0] s0_quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (advance)
            s0_valid_reg <= seg_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_side_reg <= s0_side_next;
            s0_rem_reg  <= s0_rem_next;
            s0_quo_reg  <= s0_quo_next;
        end
    end

    assign div_valid[0] = s0_valid_reg;
    assign div_side[0]  = s0_side_reg;
    assign div_rem[0]   = s0_rem_reg;
    assign div_quo[0]   = s0_quo_reg;

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        lbc_div_cell #(
            .QUO_W (QUO_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (div_valid[k]),
            .side_in   (div_side[k]),
            .rem_in    (div_rem[k]),
            .quo_in    (div_quo[k]),
            .valid_out (div_valid[k+1]),
            .side_out  (div_side[k+1]),
            .rem_out   (div_rem[k+1]),
            .quo_out   (div_quo[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Quotient to signed t, saturated to [T_MIN, T_MAX]
    // ------------------------------------------------------------------
    logic                          cv_valid_reg;
    lbc_side_t                     cv_side_reg;
    logic [NUM_LANES-1:0][T_W-1:0] cv_t_reg, cv_t_next;

    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (div_side[QUO_W].lane[i].qneg ^ div_side[QUO_W].lane[i].pneg)
            begin
                if (div_side[QUO_W].lane[i].ovf ||
                    (div_quo[QUO_W][i][QUO_W-1] && (|div_quo[QUO_W][i][QUO_W-2:0])))
                    cv_t_next[i] = T_MIN;
                else
                    cv_t_next[i] = -div_quo[QUO_W][i];
            end
            else
            begin
                if (div_side[QUO_W].lane[i].ovf || div_quo[QUO_W][i][QUO_W-1])
                    cv_t_next[i] = T_MAX;
                else
                    cv_t_next[i] = div_quo[QUO_W][i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_valid_reg <= 1'b0;
        else if (advance)
            cv_valid_reg <= div_valid[QUO_W];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cv_side_reg <= div_side[QUO_W];
            cv_t_reg    <= cv_t_next;
        end
    end

    // ------------------------------------------------------------------
    // Boundary chain: lanes in order left, right, top, bottom.
    // An extended end starts at the saturation limit of t.
    // ------------------------------------------------------------------
    logic                          bnd_valid [NUM_LANES+1];
    lbc_side_t                     bnd_side  [NUM_LANES+1];
    logic [NUM_LANES-1:0][T_W-1:0] bnd_t     [NUM_LANES+1];
    logic                          bnd_vis   [NUM_LANES+1];
    logic signed [T_W-1:0]         bnd_tmin  [NUM_LANES+1];
    logic signed [T_W-1:0]         bnd_tmax  [NUM_LANES+1];

    assign bnd_valid[0] = cv_valid_reg;
    assign bnd_side[0]  = cv_side_reg;
    assign bnd_t[0]     = cv_t_reg;
    assign bnd_vis[0]   = 1'b1;
    assign bnd_tmin[0]  = cv_side_reg.item.ext_start ? T_MIN : '0;
    assign bnd_tmax[0]  = cv_side_reg.item.ext_end ? T_MAX : T_ONE;

    for (genvar b = 0; b < NUM_LANES; b++)
    begin : g_bnd
        lbc_bound_cell #(
            .T_W (T_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (bnd_valid[b]),
            .side_in   (bnd_side[b]),
            .t_in      (bnd_t[b]),
            .vis_in    (bnd_vis[b]),
            .tmin_in   (bnd_tmin[b]),
            .tmax_in   (bnd_tmax[b]),
            .valid_out (bnd_valid[b+1]),
            .side_out  (bnd_side[b+1]),
            .t_out     (bnd_t[b+1]),
            .vis_out   (bnd_vis[b+1]),
            .tmin_out  (bnd_tmin[b+1]),
            .tmax_out  (bnd_tmax[b+1])
        );
    end

    // ------------------------------------------------------------------
    // Endpoint evaluation: four multiply units, two stages each.
    // The start is recomputed only when extended or tmin > 0, the end
    // only when extended or tmax < 1.
    // ------------------------------------------------------------------
    lbc_item_t                 last_item;
    logic                      sel_start, sel_end;
    logic signed [COORD_W-1:0] new_sx, new_sy, new_ex, new_ey;

    assign last_item = bnd_side[NUM_LANES].item;
    assign sel_start = bnd_vis[NUM_LANES] &&
                       (last_item.ext_start || (bnd_tmin[NUM_LANES] > $signed(T_W'(0))));
    assign sel_end   = bnd_vis[NUM_LANES] &&
                       (last_item.ext_end || (bnd_tmax[NUM_LANES] < T_ONE));

    lbc_along #(.T_W(T_W), .FRAC_BITS(PARAM_FRAC_BITS)) u_along_sx (
        .clk (clk), .advance (advance), .base (last_item.x1),
        .dir (last_item.dx), .t (bnd_tmin[NUM_LANES]), .coord (new_sx)
    );
    lbc_along #(.T_W(T_W), .FRAC_BITS(PARAM_FRAC_BITS)) u_along_sy (
        .clk (clk), .advance (advance), .base (last_item.y1),
        .dir (last_item.dy), .t (bnd_tmin[NUM_LANES]), .coord (new_sy)
    );
    lbc_along #(.T_W(T_W), .FRAC_BITS(PARAM_FRAC_BITS)) u_along_ex (
        .clk (clk), .advance (advance), .base (last_item.x1),
        .dir (last_item.dx), .t (bnd_tmax[NUM_LANES]), .coord (new_ex)
    );
    lbc_along #(.T_W(T_W), .FRAC_BITS(PARAM_FRAC_BITS)) u_along_ey (
        .clk (clk), .advance (advance), .base (last_item.y1),
        .dir (last_item.dy), .t (bnd_tmax[NUM_LANES]), .coord (new_ey)
    );

    // side data delayed to line up with the multiply units
    logic      a1_valid_reg, a2_valid_reg;
    lbc_item_t a1_item_reg, a2_item_reg;
    logic      a1_vis_reg, a2_vis_reg;
    logic      a1_sel_start_reg, a2_sel_start_reg;
    logic      a1_sel_end_reg, a2_sel_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_valid_reg   <= 1'b0;
            a2_valid_reg   <= 1'b0;
            clip_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a1_valid_reg   <= bnd_valid[NUM_LANES];
            a2_valid_reg   <= a1_valid_reg;
            clip_valid_reg <= a2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a1_item_reg      <= last_item;
            a1_vis_reg       <= bnd_vis[NUM_LANES];
            a1_sel_start_reg <= sel_start;
            a1_sel_end_reg   <= sel_end;
            a2_item_reg      <= a1_item_reg;
            a2_vis_reg       <= a1_vis_reg;
            a2_sel_start_reg <= a1_sel_start_reg;
            a2_sel_end_reg   <= a1_sel_end_reg;
            clip_reg         <= clip_next;
        end
    end

    // rejected or untouched ends carry the input endpoints
    always_comb
    begin
        clip_next.visible      = a2_vis_reg;
        clip_next.clip_start_x = a2_sel_start_reg ? new_sx : a2_item_reg.x1;
        clip_next.clip_start_y = a2_sel_start_reg ? new_sy : a2_item_reg.y1;
        clip_next.clip_end_x   = a2_sel_end_reg ? new_ex : a2_item_reg.x2;
        clip_next.clip_end_y   = a2_sel_end_reg ? new_ey : a2_item_reg.y2;
    end

    assign clip_valid = clip_valid_reg;
    assign clip       = clip_reg;

endmodule

// File: hw/rtl/lbc_checker.sv
// ============================================================================
// lbc_checker - port-level checks of the line rectangle clipper
// Output hold, reset behavior and input/output stall coupling.
// ============================================================================
module lbc_checker
    import lbc_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  seg_valid,
    input logic  seg_stall,
    input logic  clip_valid,
    input logic  clip_stall,
    input clip_t clip
);

    a_clip_hold: assert property (@(posedge clk) disable iff (!rst_n)
        clip_valid && clip_stall |=> clip_valid && $stable(clip))
        else $error("stalled clip transaction changed");

    // checked at the next edge so the very first edge of reset is settled
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !clip_valid)
        else $error("clip_valid high during reset");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        seg_stall == (clip_valid && clip_stall))
        else $error("seg_stall does not follow the output stall");

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && !seg_stall |-> !(clip_valid && clip_stall))
        else $error("segment taken while output was stalled");

endmodule

bind line_rect_clipper_core lbc_checker u_lbc_checker (.*);
